### hw/rtl/lze_pkg.sv
// Shared types and constants for the lattice zigzag enumeration core.
// Used by lze_mul and by the top level lattice_zigzag_enumeration_core.
`timescale 1ns / 1ps
`default_nettype none

package lze_pkg;

    // Default for the largest basis dimension.
    localparam int MAX_DIM_DEF = 64;

    // Bound on tree steps of one run, and the width of the step counter.
    localparam int STEP_W = 21;
    localparam logic [STEP_W-1:0] STEP_LIMIT = 21'd1048576;

    // Signed Q31.32 value and a signed 32-bit integer coefficient.
    typedef logic signed [63:0] q_t;
    typedef logic signed [31:0] coef_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

    localparam coef_t C_MAX = 32'sh7FFF_FFFF;
    localparam coef_t C_MIN = 32'sh8000_0000;

    // Input item actions.
    typedef enum logic [1:0] {
        ACT_LOAD_COEF = 2'd0,
        ACT_LOAD_NORM = 2'd1,
        ACT_RUN       = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

endpackage

`default_nettype wire

### hw/rtl/lze_mul.sv
// Shared Q31.32 multiplier: floor(a*b / 2^32), saturated to 64 bits.
// Four 32x32 partial products, accumulated one after another. Depends on lze_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lze_mul (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             start,
    input  lze_pkg::q_t     a,
    input  lze_pkg::q_t     b,
    output logic            done,
    output lze_pkg::q_t     result
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [2:0]   step_reg, step_next;
    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [127:0] acc_reg, acc_next;
    lze_pkg::q_t  result_reg, result_next;
    logic [127:0] pp_wide;
    logic [95:0]  q_up;

    always_comb begin
        case (step_reg[1:0])
            2'd0: begin
                pp_next = ua_reg[31:0] * ub_reg[31:0];
                sh_next = 2'd0;
            end
            2'd1: begin
                pp_next = ua_reg[31:0] * ub_reg[63:32];
                sh_next = 2'd1;
            end
            2'd2: begin
                pp_next = ua_reg[63:32] * ub_reg[31:0];
                sh_next = 2'd1;
            end
            default: begin
                pp_next = ua_reg[63:32] * ub_reg[63:32];
                sh_next = 2'd2;
            end
        endcase
    end

    always_comb begin
        case (sh_reg)
            2'd0:    pp_wide = {64'd0, pp_reg};
            2'd1:    pp_wide = {32'd0, pp_reg, 32'd0};
            default: pp_wide = {pp_reg, 64'd0};
        endcase
    end

    // Rounding toward minus infinity: a negative product with a nonzero
    // fraction moves one step further from zero.
    assign q_up = acc_reg[127:32] + {95'd0, |acc_reg[31:0]};

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                acc_next = acc_reg + pp_wide;
            end
            if (step_reg == 3'd5) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!neg_reg) begin
                    result_next = (|acc_reg[127:95]) ? lze_pkg::Q_MAX
                                                     : lze_pkg::q_t'(acc_reg[95:32]);
                end else begin
                    result_next = (|q_up[95:63]) ? lze_pkg::Q_MIN
                                                 : lze_pkg::q_t'(-q_up[63:0]);
                end
            end else begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            ua_reg  <= a[63] ? 64'(-a) : 64'(a);
            ub_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
        end
        pp_reg     <= pp_next;
        sh_reg     <= sh_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hw/rtl/lattice_zigzag_enumeration_core.sv
// Top level of the Schnorr-Euchner lattice enumeration core.
// Depends on lze_pkg and instantiates the shared multiplier lze_mul.
`timescale 1ns / 1ps
`default_nettype none

// The core holds the Gram-Schmidt coefficients and squared norms of a lattice
// basis in on-chip memories and runs a Schnorr-Euchner zigzag enumeration over
// an index window on command. Every input value is signed Q31.32. A load item
// (coefficient or norm) produces no result. A run item first clears the
// per-level memories over the window, one entry per cycle, then walks the
// enumeration tree: each partial norm takes two memory reads and two
// products through the shared multiplier, each tree step adds a decision
// state, a climb passes through ST_UP_A and ST_UP_B, and each term of a new
// center takes a memory read and one product. The tree walk is data
// dependent and is capped at 1048576 steps; after it the best coefficient
// vector leaves as one result item per window index, with m_last on the
// final index. The single multiplier sets the pace of the tree walk. The
// core takes no new input item until all results of a run have been taken.
// Memory contents are not cleared at reset; a run must only touch
// coefficients and norms that were loaded.
module lattice_zigzag_enumeration_core #(
    parameter int MAX_DIM = lze_pkg::MAX_DIM_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_action,
    input  wire  [5:0]          s_row,
    input  wire  [5:0]          s_col,
    input  wire  signed [63:0]  s_value,
    input  wire  [5:0]          s_first_index,
    input  wire  [5:0]          s_last_index,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [31:0]  m_coefficient,
    output logic [5:0]          m_index,
    output logic                m_last
);

    // Level index covers 0..MAX_DIM, basis index 0..MAX_DIM-1.
    localparam int LW = $clog2(MAX_DIM + 1);
    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM * MAX_DIM);
    localparam int LD = MAX_DIM + 1;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_INIT    = 18'h00002,
        ST_PN_A    = 18'h00004,
        ST_PN_B    = 18'h00008,
        ST_PN_M1   = 18'h00010,
        ST_PN_M2   = 18'h00020,
        ST_LOOP    = 18'h00040,
        ST_COPY_RD = 18'h00080,
        ST_COPY_WR = 18'h00100,
        ST_UP_A    = 18'h00200,
        ST_UP_B    = 18'h00400,
        ST_CEN_RD  = 18'h00800,
        ST_CEN_MS  = 18'h01000,
        ST_CEN_MW  = 18'h02000,
        ST_CEN_NEG = 18'h04000,
        ST_CEN_WR  = 18'h08000,
        ST_OUT_RD  = 18'h10000,
        ST_OUT_V   = 18'h20000
    } state_t;

    function automatic lze_pkg::q_t sat_add(input lze_pkg::q_t x, input lze_pkg::q_t y);
        logic signed [64:0] sum;
        sum = 65'({x[63], x}) + 65'({y[63], y});
        if (sum[64] != sum[63]) begin
            return sum[64] ? lze_pkg::Q_MIN : lze_pkg::Q_MAX;
        end
        return lze_pkg::q_t'(sum[63:0]);
    endfunction

    function automatic lze_pkg::coef_t sat34(input logic signed [33:0] x);
        if (x > 34'sd2147483647) begin
            return lze_pkg::C_MAX;
        end
        if (x < -34'sd2147483648) begin
            return lze_pkg::C_MIN;
        end
        return lze_pkg::coef_t'(x[31:0]);
    endfunction

    // Round half away from zero to a saturated 32-bit integer.
    function automatic lze_pkg::coef_t round_q(input lze_pkg::q_t x);
        logic [63:0] mag;
        logic [63:0] sum;
        logic [31:0] m;
        mag = x[63] ? 64'(-x) : 64'(x);
        sum = mag + 64'h0000_0000_8000_0000;
        m   = sum[63:32];
        if (!x[63]) begin
            return m[31] ? lze_pkg::C_MAX : lze_pkg::coef_t'(m);
        end
        return (m > 32'h8000_0000) ? lze_pkg::C_MIN : lze_pkg::coef_t'(-m);
    endfunction

    // Stores.
    lze_pkg::q_t   coef_mem [MAX_DIM*MAX_DIM];
    lze_pkg::q_t   norm_mem [MAX_DIM];
    lze_pkg::q_t   pn_mem   [LD];
    lze_pkg::q_t   cen_mem  [LD];
    lze_pkg::coef_t tc_mem  [LD];
    lze_pkg::coef_t rc_mem  [LD];
    lze_pkg::coef_t so_mem  [LD];
    logic          ss_mem   [LD];
    lze_pkg::coef_t best_mem [MAX_DIM];

    lze_pkg::q_t    coef_rd, norm_rd, pn_rd, cen_rd;
    lze_pkg::coef_t tc_rd, rc_rd, so_rd, best_rd;
    logic           ss_rd;

    // Sequencer registers; t is the current level and s the highest level
    // reached so far.
    state_t               state_reg, state_next;
    logic [LW-1:0]        t_reg, t_next;
    logic [LW-1:0]        s_reg, s_next;
    logic [LW-1:0]        i_reg, i_next;
    logic [LW-1:0]        lo_reg, lo_next;
    logic [LW-1:0]        hi_reg, hi_next;
    logic [lze_pkg::STEP_W-1:0] steps_reg, steps_next;
    lze_pkg::q_t          best_norm_reg, best_norm_next;
    lze_pkg::q_t          cur_pn_reg, cur_pn_next;
    lze_pkg::q_t          acc_reg, acc_next;
    lze_pkg::q_t          neg_reg, neg_next;

    // Memory ports.
    logic [LW-1:0]  lv_raddr, lv_waddr;
    logic           pn_we, cen_we, tc_we, rc_we, so_we, ss_we, best_we;
    lze_pkg::q_t    pn_wdata, cen_wdata;
    lze_pkg::coef_t tc_wdata, rc_wdata, so_wdata, best_wdata;
    logic           ss_wdata;
    logic [IW-1:0]  best_waddr, norm_raddr;
    logic [CW-1:0]  coef_raddr, coef_waddr;
    logic           coef_we, norm_we;

    // Shared multiplier.
    logic        mul_start, mul_done;
    lze_pkg::q_t mul_a, mul_b, mul_result;

    lze_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_result)
    );

    logic          in_fire;
    logic [6:0]    lo_in, hi_in, hi_sat;
    logic [LW-1:0] top_lvl;
    logic [LW-1:0] t_up;
    logic signed [33:0] off, off_adj, tc_sum;
    lze_pkg::coef_t so_new, r_new;
    lze_pkg::q_t    e_val, r_q;

    assign in_fire = s_valid && s_ready;
    assign lo_in   = {1'b0, s_first_index};
    assign hi_in   = {1'b0, s_last_index};
    assign hi_sat  = (hi_in > 7'(MAX_DIM - 1)) ? 7'(MAX_DIM - 1) : hi_in;
    assign top_lvl = (s_reg < hi_reg) ? s_reg : hi_reg;
    assign t_up    = t_reg + LW'(1);

    assign coef_waddr = CW'(s_row) * CW'(MAX_DIM) + CW'(s_col);
    assign coef_we    = in_fire && (s_action == lze_pkg::ACT_LOAD_COEF)
                        && (s_row < 6'(MAX_DIM - 1) + 6'd1 || MAX_DIM == 64)
                        && (s_col < 6'(MAX_DIM - 1) + 6'd1 || MAX_DIM == 64);
    assign norm_we    = in_fire && (s_action == lze_pkg::ACT_LOAD_NORM)
                        && (s_row < 6'(MAX_DIM - 1) + 6'd1 || MAX_DIM == 64);

    assign coef_raddr = CW'(i_reg) * CW'(MAX_DIM) + CW'(t_reg);
    assign norm_raddr = (state_reg == ST_INIT) ? lo_reg[IW-1:0] : t_reg[IW-1:0];

    // Step of a coefficient one level up: the zigzag around the rounded center.
    always_comb begin
        off = 34'(so_rd);
        if (t_reg < s_reg) begin
            off = -off;
        end
        off_adj = off;
        if (off == 34'sd0 || (off < 34'sd0) == ss_rd) begin
            off_adj = off + (ss_rd ? -34'sd1 : 34'sd1);
        end
        so_new = sat34(off_adj);
        tc_sum = 34'(rc_rd) + 34'(so_new);
    end

    assign e_val = sat_add(cen_rd, lze_pkg::q_t'({tc_rd, 32'h0}));
    assign r_new = round_q(neg_reg);
    assign r_q   = lze_pkg::q_t'({r_new, 32'h0});

    always_comb begin
        case (state_reg)
            ST_PN_A, ST_UP_A:                 lv_raddr = t_reg;
            ST_PN_B, ST_PN_M1, ST_PN_M2:      lv_raddr = t_up;
            ST_CEN_RD, ST_COPY_RD:            lv_raddr = i_reg;
            default:                          lv_raddr = t_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        steps_next     = steps_reg;
        best_norm_next = best_norm_reg;
        cur_pn_next    = cur_pn_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;

        lv_waddr   = t_reg;
        pn_we      = 1'b0;
        cen_we     = 1'b0;
        tc_we      = 1'b0;
        rc_we      = 1'b0;
        so_we      = 1'b0;
        ss_we      = 1'b0;
        best_we    = 1'b0;
        pn_wdata   = '0;
        cen_wdata  = '0;
        tc_wdata   = '0;
        rc_wdata   = '0;
        so_wdata   = '0;
        ss_wdata   = 1'b0;
        best_wdata = '0;
        best_waddr = i_reg[IW-1:0];

        mul_start = 1'b0;
        mul_a     = e_val;
        mul_b     = e_val;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_action == lze_pkg::ACT_RUN && lo_in <= hi_sat) begin
                    lo_next    = LW'(lo_in);
                    hi_next    = LW'(hi_sat);
                    i_next     = LW'(lo_in);
                    t_next     = LW'(lo_in);
                    s_next     = LW'(lo_in);
                    steps_next = '0;
                    state_next = ST_INIT;
                end
            end
            // Clear levels lo..hi+1; level lo starts with coefficient one.
            ST_INIT: begin
                lv_waddr = i_reg;
                pn_we    = 1'b1;
                cen_we   = 1'b1;
                tc_we    = 1'b1;
                rc_we    = 1'b1;
                so_we    = 1'b1;
                ss_we    = 1'b1;
                tc_wdata = (i_reg == lo_reg) ? 32'sd1 : 32'sd0;
                best_we    = (i_reg < LW'(MAX_DIM));
                best_wdata = tc_wdata;
                if (i_reg == hi_reg + LW'(1)) begin
                    best_norm_next = norm_rd;
                    state_next     = ST_PN_A;
                end else begin
                    i_next = i_reg + LW'(1);
                end
            end
            ST_PN_A: begin
                state_next = ST_PN_B;
            end
            ST_PN_B: begin
                mul_start  = 1'b1;
                state_next = ST_PN_M1;
            end
            ST_PN_M1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_result;
                    mul_b      = norm_rd;
                    state_next = ST_PN_M2;
                end
            end
            ST_PN_M2: begin
                if (mul_done) begin
                    pn_we       = 1'b1;
                    pn_wdata    = sat_add(pn_rd, mul_result);
                    cur_pn_next = pn_wdata;
                    state_next  = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (steps_reg == lze_pkg::STEP_LIMIT) begin
                    i_next     = lo_reg;
                    state_next = ST_OUT_RD;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    if (cur_pn_reg < best_norm_reg && t_reg <= lo_reg) begin
                        // A shorter vector: keep its norm and coefficients.
                        best_norm_next = cur_pn_reg;
                        i_next         = lo_reg;
                        state_next     = ST_COPY_RD;
                    end else if (cur_pn_reg >= best_norm_reg) begin
                        t_next = t_up;
                        if (s_reg < t_up) begin
                            s_next = t_up;
                        end
                        if (t_up > hi_reg) begin
                            i_next     = lo_reg;
                            state_next = ST_OUT_RD;
                        end else begin
                            state_next = ST_UP_A;
                        end
                    end else begin
                        t_next     = t_reg - LW'(1);
                        i_next     = t_reg;
                        acc_next   = '0;
                        state_next = ST_CEN_RD;
                    end
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                best_we    = 1'b1;
                best_wdata = tc_rd;
                if (i_reg == hi_reg) begin
                    state_next = ST_LOOP;
                end else begin
                    i_next     = i_reg + LW'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_UP_A: begin
                state_next = ST_UP_B;
            end
            ST_UP_B: begin
                so_we      = 1'b1;
                so_wdata   = so_new;
                tc_we      = 1'b1;
                tc_wdata   = sat34(tc_sum);
                state_next = ST_PN_A;
            end
            ST_CEN_RD: begin
                state_next = ST_CEN_MS;
            end
            ST_CEN_MS: begin
                mul_start  = 1'b1;
                mul_a      = lze_pkg::q_t'({tc_rd, 32'h0});
                mul_b      = coef_rd;
                state_next = ST_CEN_MW;
            end
            ST_CEN_MW: begin
                if (mul_done) begin
                    acc_next = sat_add(acc_reg, mul_result);
                    if (i_reg >= top_lvl) begin
                        state_next = ST_CEN_NEG;
                    end else begin
                        i_next     = i_reg + LW'(1);
                        state_next = ST_CEN_RD;
                    end
                end
            end
            ST_CEN_NEG: begin
                neg_next   = (acc_reg == lze_pkg::Q_MIN) ? lze_pkg::Q_MAX : -acc_reg;
                state_next = ST_CEN_WR;
            end
            // New level: center, rounded start point and zigzag direction.
            ST_CEN_WR: begin
                cen_we     = 1'b1;
                cen_wdata  = acc_reg;
                rc_we      = 1'b1;
                rc_wdata   = r_new;
                tc_we      = 1'b1;
                tc_wdata   = r_new;
                so_we      = 1'b1;
                ss_we      = 1'b1;
                ss_wdata   = (r_q > neg_reg);
                state_next = ST_PN_A;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_V;
            end
            ST_OUT_V: begin
                if (m_ready) begin
                    if (i_reg == hi_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + LW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            s_reg         <= '0;
            i_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            steps_reg     <= '0;
            best_norm_reg <= '0;
        end else begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            s_reg         <= s_next;
            i_reg         <= i_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            steps_reg     <= steps_next;
            best_norm_reg <= best_norm_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_pn_reg <= cur_pn_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= s_value;
        end
        if (norm_we) begin
            norm_mem[s_row[IW-1:0]] <= s_value;
        end
        if (pn_we) begin
            pn_mem[lv_waddr] <= pn_wdata;
        end
        if (cen_we) begin
            cen_mem[lv_waddr] <= cen_wdata;
        end
        if (tc_we) begin
            tc_mem[lv_waddr] <= tc_wdata;
        end
        if (rc_we) begin
            rc_mem[lv_waddr] <= rc_wdata;
        end
        if (so_we) begin
            so_mem[lv_waddr] <= so_wdata;
        end
        if (ss_we) begin
            ss_mem[lv_waddr] <= ss_wdata;
        end
        if (best_we) begin
            best_mem[best_waddr] <= best_wdata;
        end
        coef_rd <= coef_mem[coef_raddr];
        norm_rd <= norm_mem[norm_raddr];
        pn_rd   <= pn_mem[lv_raddr];
        cen_rd  <= cen_mem[lv_raddr];
        tc_rd   <= tc_mem[lv_raddr];
        rc_rd   <= rc_mem[lv_raddr];
        so_rd   <= so_mem[lv_raddr];
        ss_rd   <= ss_mem[lv_raddr];
        best_rd <= best_mem[i_reg[IW-1:0]];
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT_V);
    assign m_coefficient = best_rd;
    assign m_index       = 6'(i_reg);
    assign m_last        = (i_reg == hi_reg);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_index == 6'(hi_reg)))
        else $error("last flag away from the window end");

    a_mul_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_PN_M1 || state_reg == ST_PN_M2
                      || state_reg == ST_CEN_MW))
        else $error("multiplier result arrived outside a wait state");
`endif

endmodule

`default_nettype wire
